// ===== hdl/ilp_pkg.sv =====
// Integer literal parser: shared types and codes.
// Used by ilp_step, integer_literal_parser_unit and ilp_checker.
`timescale 1ns / 1ps

package ilp_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ACC_W  = 64;
    localparam int unsigned NUM_W  = 63;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OUT_TDATA_W = 72;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2,
        RADIX_OCT = 2'd3
    } t_radix;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]       position;
        logic             first_was_zero;
        t_radix           radix_code;
        logic             seen_digit;
        logic             prev_underscore;
        logic [ACC_W-1:0] accum;
        t_status          error_code;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        position:        2'd0,
        first_was_zero:  1'b0,
        radix_code:      RADIX_DEC,
        seen_digit:      1'b0,
        prev_underscore: 1'b0,
        accum:           '0,
        error_code:      ST_OK
    };

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
    localparam logic [CHAR_W-1:0] CH_LO_O  = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_UP_O  = 8'h4F;

endpackage

// ===== hdl/ilp_step.sv =====
// Per-character next-state logic of the integer literal parser, plus the
// end-of-token status and value. Purely combinational; depends on ilp_pkg.
`timescale 1ns / 1ps

module ilp_step (
    input  ilp_pkg::t_state              i_state,
    input  logic [ilp_pkg::CHAR_W-1:0]   i_char,
    output ilp_pkg::t_state              o_next,
    output ilp_pkg::t_status             o_status,
    output logic [ilp_pkg::NUM_W-1:0]    o_number
);
    import ilp_pkg::*;

    logic [4:0]        w_digit;
    logic              w_digit_ok;
    logic              w_is_prefix;
    logic [ACC_W+3:0]  w_prod;
    logic [ACC_W+3:0]  w_acc_ext;
    logic [7:0]        w_off_num;
    logic [7:0]        w_off_lo;
    logic [7:0]        w_off_up;

    assign w_off_num = i_char - CH_0;
    assign w_off_lo  = i_char - CH_LO_A + 8'd10;
    assign w_off_up  = i_char - CH_UP_A + 8'd10;

    always_comb begin
        w_digit = 5'd16;
        if (i_char >= CH_0 && i_char <= CH_9) begin
            w_digit = w_off_num[4:0];
        end else if (i_char >= CH_LO_A && i_char <= CH_LO_F) begin
            w_digit = w_off_lo[4:0];
        end else if (i_char >= CH_UP_A && i_char <= CH_UP_F) begin
            w_digit = w_off_up[4:0];
        end
    end

    assign w_acc_ext = {4'b0, i_state.accum};

    // value * base + digit as shift-adds; bits above 63 mean carry out
    always_comb begin
        unique case (i_state.radix_code)
            RADIX_HEX: begin
                w_digit_ok = (w_digit < 5'd16);
                w_prod     = (w_acc_ext << 4);
            end
            RADIX_BIN: begin
                w_digit_ok = (w_digit < 5'd2);
                w_prod     = (w_acc_ext << 1);
            end
            RADIX_OCT: begin
                w_digit_ok = (w_digit < 5'd8);
                w_prod     = (w_acc_ext << 3);
            end
            default: begin
                w_digit_ok = (w_digit < 5'd10);
                w_prod     = (w_acc_ext << 3) + (w_acc_ext << 1);
            end
        endcase
    end

    logic [ACC_W+3:0] w_sum;
    assign w_sum = w_prod + {{(ACC_W-1){1'b0}}, w_digit};

    assign w_is_prefix = (i_state.position == 2'd1) && i_state.first_was_zero &&
                         (i_char == CH_LO_X || i_char == CH_UP_X ||
                          i_char == CH_LO_B || i_char == CH_UP_B ||
                          i_char == CH_LO_O || i_char == CH_UP_O);

    always_comb begin
        o_next = i_state;
        if (i_state.position != 2'd2) begin
            o_next.position = i_state.position + 2'd1;
        end
        if (i_state.error_code == ST_OK) begin
            if (w_is_prefix) begin
                if (i_char == CH_LO_X || i_char == CH_UP_X) begin
                    o_next.radix_code = RADIX_HEX;
                end else if (i_char == CH_LO_B || i_char == CH_UP_B) begin
                    o_next.radix_code = RADIX_BIN;
                end else begin
                    o_next.radix_code = RADIX_OCT;
                end
                o_next.accum           = '0;
                o_next.seen_digit      = 1'b0;
                o_next.prev_underscore = 1'b0;
            end else if (i_char == CH_UNDER) begin
                if (!i_state.seen_digit || i_state.prev_underscore) begin
                    o_next.error_code = ST_INVALID;
                end else begin
                    o_next.prev_underscore = 1'b1;
                end
            end else if (!w_digit_ok) begin
                o_next.error_code = ST_INVALID;
            end else if (w_sum[ACC_W+3:ACC_W] != 4'd0) begin
                o_next.error_code = ST_OVERFLOW;
            end else begin
                o_next.accum           = w_sum[ACC_W-1:0];
                o_next.seen_digit      = 1'b1;
                o_next.prev_underscore = 1'b0;
                if (i_state.position == 2'd0 && i_char == CH_0) begin
                    o_next.first_was_zero = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_status = o_next.error_code;
        o_number = '0;
        if (o_next.error_code == ST_OK) begin
            if (!o_next.seen_digit || o_next.prev_underscore) begin
                o_status = ST_INVALID;
            end else if (o_next.accum[ACC_W-1]) begin
                o_status = ST_OVERFLOW;
            end else begin
                o_number = o_next.accum[NUM_W-1:0];
            end
        end
    end

endmodule

// ===== hdl/integer_literal_parser_unit.sv =====
// Integer literal parser, top level: input register, token state, result register.
// Depends on ilp_pkg and ilp_step.
`timescale 1ns / 1ps
//
// Usage:
//   Slave channel carries one token character per request: tdata[7:0] is the
//   character byte, tlast marks the final character of the token. Prefixes
//   0x/0b/0o (any case) select base 16/2/8, otherwise base 10; single
//   underscores between digits are accepted.
//   Master channel carries one result per token, issued on its last
//   character: tdata[1:0] status (0 ok, 1 invalid, 2 overflow),
//   tdata[64:2] value (zero unless ok), tdata[71:65] zero.
//   Throughput: one character per cycle while no last character waits on a
//   stalled result. A character is captured in the input register, then
//   folded into the token state (one shift-add on the 64-bit accumulator
//   with carry check) when it leaves the input register; the result is
//   registered in the output register when its last character is folded in.
//   When the receiver stalls, characters that end no token keep flowing;
//   a last character waits in the input register and tready drops until
//   the held result is taken.
//   Synchronous reset clears the token state and both valid flags.

module integer_literal_parser_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ilp_pkg::CHAR_W-1:0]       i_s_tdata,  // [7:0] char_code
    input  logic                             i_s_tlast,  // is_last
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ilp_pkg::OUT_TDATA_W-1:0]  o_m_tdata   // [1:0] status, [64:2] number
);
    import ilp_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;
    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [NUM_W-1:0]  r_out_number;

    t_status           w_status;
    logic [NUM_W-1:0]  w_number;
    logic              w_out_free;
    logic              w_proc;

    ilp_step u_step (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .o_next   (n_state),
        .o_status (w_status),
        .o_number (w_number)
    );

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_proc     = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_tready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (w_proc) begin
            r_state <= r_in_last ? STATE_CLEAR : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_last) begin
            r_out_status <= w_status;
            r_out_number <= w_number;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - NUM_W - STAT_W){1'b0}}, r_out_number, r_out_status};

endmodule

// ===== hdl/ilp_checker.sv =====
// Port-level checks for integer_literal_parser_unit, bound to the top level.
// Depends on ilp_pkg.
`timescale 1ns / 1ps

module ilp_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             o_s_tready,
    input  logic [ilp_pkg::CHAR_W-1:0]       i_s_tdata,
    input  logic                             i_s_tlast,
    input  logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [ilp_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import ilp_pkg::*;

    // held result must stay put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_m_tvalid) && !$past(i_m_tready)
        |-> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == ST_OK || o_m_tdata[1:0] == ST_INVALID ||
                        o_m_tdata[1:0] == ST_OVERFLOW))
        else $error("status out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != ST_OK |-> o_m_tdata[OUT_TDATA_W-1:STAT_W] == '0)
        else $error("nonzero value with error status");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled without output backpressure");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind integer_literal_parser_unit ilp_checker u_ilp_checker (.*);
